### rtl/core/etrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etrb_pkg: shared definitions for the event trace ring buffer
// Depth, index widths, record layout and the action codes of an input beat.
// ----------------------------------------------------------------------------
package etrb_pkg;

  // Buffer geometry
  localparam int DEPTH        = 256;
  localparam int RECORD_WORDS = 8;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int WORD_W       = 16;
  localparam int REC_W        = RECORD_WORDS * WORD_W;

  // Stream widths
  localparam int IN_DATA_W  = 128;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  // Action codes
  typedef enum logic [1:0] {
    ACT_RECORD = 2'd0,
    ACT_START  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Write and read requests toward the record store
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } store_req_t;

endpackage : etrb_pkg
`default_nettype wire

### rtl/core/etrb_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etrb_store: record memory with per-entry valid bits
// One write and one registered read per cycle; an entry never written since
// reset reads as all zeros.
// ----------------------------------------------------------------------------
module etrb_store
  import etrb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire store_req_t       req,
  input  wire logic [REC_W-1:0] wr_data,
  output logic      [REC_W-1:0] rd_data
);

  logic [REC_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [REC_W-1:0] rd_q;
  logic             rd_valid_q;

  // Write the record array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  // Mark written entries; reset empties the whole store
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  // Register the read data and its valid bit; hold between reads
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q       <= mem[req.rd_addr];
      rd_valid_q <= valid[req.rd_addr];
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule : etrb_store
`default_nettype wire

### rtl/core/event_trace_ring_buffer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// event_trace_ring_buffer_top: circular event trace buffer
// Stores eight-word event records in a ring and returns them oldest first,
// two 16-bit words per read beat.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser: action; s_tdata: code, params, stamps
//  m_*      out  m_tvalid/m_tready  m_tdata: word_low, word_high
//
//  One input beat is taken per cycle when the output is not blocked.
//  Start and read beats raise m_tvalid from the output register: the
//  store read and the result stage register at acceptance, the output
//  register when the result stage moves on. Record and clear beats give no
//  result and update state at acceptance. A stalled output holds the result
//  stage; s_tready drops only while the result stage holds a beat and the
//  output register holds a stalled one.
//  Synchronous reset empties the buffer; there is no clearing pass.
// ----------------------------------------------------------------------------
module event_trace_ring_buffer_top
  import etrb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // [1:0] action
  input  wire logic [IN_USER_W-1:0]  s_tuser,
  // [15:0] evt_code, [31:16] param_one, [47:32] param_two,
  // [63:48] param_three, [95:64] tick_count, [127:96] sub_count
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [15:0] word_low, [31:16] word_high
  output logic      [OUT_DATA_W-1:0] m_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready
);

  // Unpack the input beat
  action_t     action;
  logic [15:0] evt_code, param_one, param_two, param_three;
  logic [31:0] tick_count, sub_count;

  assign action      = action_t'(s_tuser);
  assign evt_code    = s_tdata[15:0];
  assign param_one   = s_tdata[31:16];
  assign param_two   = s_tdata[47:32];
  assign param_three = s_tdata[63:48];
  assign tick_count  = s_tdata[95:64];
  assign sub_count   = s_tdata[127:96];

  // Ring state
  logic [IDX_W-1:0] write_index, write_index_next;
  logic [CNT_W-1:0] stored_count;
  logic [IDX_W-1:0] read_record, read_record_next;
  logic [1:0]       read_pair;

  // Result stage between store read and output register
  logic             s1_valid;
  logic             s1_start;
  logic [1:0]       s1_pair;
  logic [CNT_W-1:0] s1_avail;
  logic             s1_move;
  logic             accept;

  logic             full;
  logic [IDX_W:0]   phys_sum;
  logic [IDX_W-1:0] phys;
  store_req_t       req;
  logic [REC_W-1:0] wr_data;
  logic [REC_W-1:0] rd_data;

  // Handshake: take a beat unless both result stage and output are blocked
  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Wrap helpers for write index and read record
  assign write_index_next = (write_index == IDX_W'(DEPTH - 1)) ? '0 : write_index + 1'b1;
  assign read_record_next = (read_record == IDX_W'(DEPTH - 1)) ? '0 : read_record + 1'b1;

  // Physical address of the record being read, oldest first
  assign full     = (stored_count == CNT_W'(DEPTH));
  assign phys_sum = {1'b0, write_index} + {1'b0, read_record};
  always_comb begin
    if (!full) begin
      phys = read_record;
    end else if (phys_sum >= (IDX_W + 1)'(DEPTH)) begin
      phys = IDX_W'(phys_sum - (IDX_W + 1)'(DEPTH));
    end else begin
      phys = phys_sum[IDX_W-1:0];
    end
  end

  // Store requests
  assign req.wr_en   = accept && (action == ACT_RECORD);
  assign req.wr_addr = write_index;
  assign req.rd_en   = accept && (action == ACT_READ);
  assign req.rd_addr = phys;
  assign wr_data     = {sub_count, tick_count, param_three, param_two, param_one, evt_code};

  etrb_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Advance ring and reader state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index  <= '0;
      stored_count <= '0;
      read_record  <= '0;
      read_pair    <= '0;
    end else if (accept) begin
      case (action)
        ACT_RECORD: begin
          write_index <= write_index_next;
          if (!full) begin
            stored_count <= stored_count + 1'b1;
          end
        end
        ACT_START: begin
          read_record <= '0;
          read_pair   <= '0;
        end
        ACT_READ: begin
          read_pair <= read_pair + 1'b1;
          if (read_pair == 2'd3) begin
            read_record <= read_record_next;
          end
        end
        ACT_CLEAR: begin
          write_index  <= '0;
          stored_count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (action == ACT_START) || (action == ACT_READ);
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Result stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_start <= (action == ACT_START);
      s1_pair  <= read_pair;
      s1_avail <= stored_count;
    end
  end

  // Select the word pair or the start-read summary
  logic [WORD_W-1:0] res_low, res_high;
  always_comb begin
    if (s1_start) begin
      res_low  = WORD_W'(RECORD_WORDS);
      res_high = WORD_W'(s1_avail);
    end else begin
      res_low  = rd_data[{s1_pair, 1'b0} * WORD_W +: WORD_W];
      res_high = rd_data[{s1_pair, 1'b1} * WORD_W +: WORD_W];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= {res_high, res_low};
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(DEPTH))
    else $error("stored count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_RECORD && !full) |=> stored_count == $past(stored_count) + 1'b1)
    else $error("record did not advance count");

  a_start_rewind: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_START) |=> (read_record == '0 && read_pair == '0))
    else $error("start-read did not rewind reader");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result path blocked");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> s1_valid)
    else $error("pending result lost");

endmodule : event_trace_ring_buffer_top
`default_nettype wire
